// ===== rtl/rbd_pkg.sv =====
`default_nettype none
// ============================================================================
// rbd_pkg
// Shared sizes, box edge tables and payload types of the RGB565 box
// downscaler.
// ============================================================================
package rbd_pkg;

    localparam int SRC_WIDTH  = 320;
    localparam int SRC_HEIGHT = 240;
    localparam int DST_WIDTH  = 160;
    localparam int DST_HEIGHT = 128;

    // port field widths
    localparam int PIX_W     = 16;
    localparam int COL_OUT_W = 8;
    localparam int ROW_OUT_W = 7;

    // RGB565 field layout
    localparam int RED_POS = 11;
    localparam int GRN_POS = 5;
    localparam int BLU_POS = 0;
    localparam int RED_W   = 5;
    localparam int GRN_W   = 6;
    localparam int BLU_W   = 5;
    localparam int CHAN_MAX = 63;

    // channel slots in a packed sum vector
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    localparam int SCOL_W = $clog2(SRC_WIDTH + 1);
    localparam int SROW_W = $clog2(SRC_HEIGHT + 1);
    localparam int DCOL_W = $clog2(DST_WIDTH + 1);
    localparam int DROW_W = $clog2(DST_HEIGHT + 1);
    localparam int ADDR_W = (DST_WIDTH > 1) ? $clog2(DST_WIDTH) : 1;

    localparam int BOX_W_MAX = (SRC_WIDTH + DST_WIDTH - 1) / DST_WIDTH;
    localparam int BOX_H_MAX = (SRC_HEIGHT + DST_HEIGHT - 1) / DST_HEIGHT;
    localparam int BW_W      = $clog2(BOX_W_MAX + 1);
    localparam int BH_W      = $clog2(BOX_H_MAX + 1);
    localparam int CNT_MAX   = BOX_W_MAX * BOX_H_MAX;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int SUM_W     = $clog2(CHAN_MAX * CNT_MAX + 1);
    localparam int QUO_W     = GRN_W;

    typedef logic [DST_WIDTH:0][SCOL_W-1:0]  col_tab_t;
    typedef logic [DST_HEIGHT:0][SROW_W-1:0] row_tab_t;

    function automatic col_tab_t build_col_tab();
        col_tab_t t;
        for (int i = 0; i <= DST_WIDTH; i++)
        begin
            t[i] = SCOL_W'((i * SRC_WIDTH) / DST_WIDTH);
        end
        return t;
    endfunction

    function automatic row_tab_t build_row_tab();
        row_tab_t t;
        for (int i = 0; i <= DST_HEIGHT; i++)
        begin
            t[i] = SROW_W'((i * SRC_HEIGHT) / DST_HEIGHT);
        end
        return t;
    endfunction

    // box i spans [EDGE[i], EDGE[i+1])
    localparam col_tab_t COL_EDGE = build_col_tab();
    localparam row_tab_t ROW_EDGE = build_row_tab();

    typedef logic [SUM_W-1:0] sum_t;
    typedef sum_t [2:0]       rgb_sum_t;
    typedef logic [QUO_W-1:0] quo_t;
    typedef quo_t [2:0]       rgb_quo_t;

    typedef struct packed {
        logic [DCOL_W-1:0] col;
        logic [DROW_W-1:0] row;
        logic              row_done;
    } box_tag_t;

    typedef struct packed {
        logic              col_last;
        logic              row_last;
        logic              first_row;
        logic [ADDR_W-1:0] addr;
        logic [BW_W-1:0]   cw;
        logic [BH_W-1:0]   rh;
        box_tag_t          tag;
    } acc_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/rgb565_box_downscaler_unit.sv =====
`default_nettype none
// ============================================================================
// rgb565_box_downscaler_unit
// Box-averaging downscaler for RGB565 raster streams.
// ============================================================================
// Source pixels enter on src_pixel/frame_start under src_valid/src_stall, in
// raster order; frame_start on an item restarts the frame position at it.
// One averaged pixel leaves on dst_pixel with dst_col, dst_row and row_done
// under dst_valid/dst_stall, for each item that completes a box (the bottom
// right source pixel of the box).
// Throughput: one item per clock while the output is not stalled. The only
// loop is the source position and running row-segment sum; the line store
// read-add-write and the divider are pipelined.
// Path: a completing item passes the line store stage register, the divider
// input register and 6 divider stages, one quotient bit each, before its
// result shows on dst_valid.
// Stall: a held result in the output stage freezes the whole pipeline and
// raises src_stall in the same cycle; nothing is dropped.
// Reset: positions and sums go to the start of a frame at once; the line
// store needs no clearing, since the first source row of every box row
// ignores what it holds.
// ============================================================================
module rgb565_box_downscaler_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          src_valid,
    output logic                               src_stall,
    input  wire logic [rbd_pkg::PIX_W-1:0]     src_pixel,
    input  wire logic                          frame_start,
    output logic                               dst_valid,
    input  wire logic                          dst_stall,
    output logic [rbd_pkg::PIX_W-1:0]          dst_pixel,
    output logic [rbd_pkg::COL_OUT_W-1:0]      dst_col,
    output logic [rbd_pkg::ROW_OUT_W-1:0]      dst_row,
    output logic                               row_done
);

    localparam int SCOL_W    = rbd_pkg::SCOL_W;
    localparam int SROW_W    = rbd_pkg::SROW_W;
    localparam int DCOL_W    = rbd_pkg::DCOL_W;
    localparam int DROW_W    = rbd_pkg::DROW_W;
    localparam int SUM_W     = rbd_pkg::SUM_W;
    localparam int BW_W      = rbd_pkg::BW_W;
    localparam int BH_W      = rbd_pkg::BH_W;
    localparam int COL_OUT_W = rbd_pkg::COL_OUT_W;
    localparam int ROW_OUT_W = rbd_pkg::ROW_OUT_W;

    logic [SCOL_W-1:0] col_cnt_reg;
    logic [SROW_W-1:0] row_cnt_reg;
    logic [DCOL_W-1:0] bcol_reg;
    logic [DROW_W-1:0] brow_reg;
    rbd_pkg::rgb_sum_t run_reg;

    logic adv;
    logic accept;

    logic [SCOL_W-1:0] col_cnt, col_cnt_inc, col_lo, col_hi;
    logic [SROW_W-1:0] row_cnt, row_cnt_inc, row_lo, row_hi;
    logic [DCOL_W-1:0] bcol, bcol_inc;
    logic [DROW_W-1:0] brow, brow_inc;
    logic              col_last, row_last, first_row, col_end, row_end;
    rbd_pkg::rgb_sum_t run, chan, run_tot;
    rbd_pkg::acc_ctrl_t ctrl;

    logic                       div_valid;
    rbd_pkg::rgb_sum_t          div_tot;
    logic [rbd_pkg::CNT_W-1:0]  div_cnt;
    rbd_pkg::box_tag_t          div_tag;
    rbd_pkg::rgb_quo_t          quo;
    rbd_pkg::box_tag_t          tag_o;

    // the pipeline moves whenever the output stage is free or being taken
    assign adv       = !dst_valid || !dst_stall;
    assign src_stall = !adv;
    assign accept    = src_valid && adv;

    always_comb
    begin
        col_cnt = frame_start ? '0 : col_cnt_reg;
        row_cnt = frame_start ? '0 : row_cnt_reg;
        bcol    = frame_start ? '0 : bcol_reg;
        brow    = frame_start ? '0 : brow_reg;
        run     = frame_start ? '0 : run_reg;

        col_cnt_inc = col_cnt + 1'b1;
        row_cnt_inc = row_cnt + 1'b1;
        bcol_inc    = bcol + 1'b1;
        brow_inc    = brow + 1'b1;

        col_lo = rbd_pkg::COL_EDGE[bcol];
        col_hi = rbd_pkg::COL_EDGE[bcol_inc];
        row_lo = rbd_pkg::ROW_EDGE[brow];
        row_hi = rbd_pkg::ROW_EDGE[brow_inc];

        col_last  = col_cnt_inc >= col_hi;
        row_last  = row_cnt_inc >= row_hi;
        first_row = row_cnt <= row_lo;
        col_end   = col_cnt_inc >= SCOL_W'(rbd_pkg::SRC_WIDTH);
        row_end   = row_cnt_inc >= SROW_W'(rbd_pkg::SRC_HEIGHT);

        chan[rbd_pkg::CH_R] = SUM_W'(src_pixel[rbd_pkg::RED_POS +: rbd_pkg::RED_W]);
        chan[rbd_pkg::CH_G] = SUM_W'(src_pixel[rbd_pkg::GRN_POS +: rbd_pkg::GRN_W]);
        chan[rbd_pkg::CH_B] = SUM_W'(src_pixel[rbd_pkg::BLU_POS +: rbd_pkg::BLU_W]);
        for (int k = 0; k < 3; k++)
        begin
            run_tot[k] = run[k] + chan[k];
        end

        ctrl.col_last     = col_last;
        ctrl.row_last     = row_last;
        ctrl.first_row    = first_row;
        ctrl.addr         = bcol[rbd_pkg::ADDR_W-1:0];
        ctrl.cw           = BW_W'(col_hi - col_lo);
        ctrl.rh           = BH_W'(row_hi - row_lo);
        ctrl.tag.col      = bcol;
        ctrl.tag.row      = brow;
        ctrl.tag.row_done = bcol_inc >= DCOL_W'(rbd_pkg::DST_WIDTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            bcol_reg    <= '0;
            brow_reg    <= '0;
            run_reg     <= '0;
        end
        else if (accept)
        begin
            run_reg <= (col_last || col_end) ? '0 : run_tot;
            if (col_end)
            begin
                col_cnt_reg <= '0;
                bcol_reg    <= '0;
                if (row_end)
                begin
                    row_cnt_reg <= '0;
                    brow_reg    <= '0;
                end
                else
                begin
                    row_cnt_reg <= row_cnt_inc;
                    brow_reg    <= row_last ? brow_inc : brow;
                end
            end
            else
            begin
                col_cnt_reg <= col_cnt_inc;
                bcol_reg    <= col_last ? bcol_inc : bcol;
                row_cnt_reg <= row_cnt;
                brow_reg    <= brow;
            end
        end
    end

    rbd_column_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (accept),
        .in_ctrl   (ctrl),
        .in_run    (run_tot),
        .out_valid (div_valid),
        .out_tot   (div_tot),
        .out_cnt   (div_cnt),
        .out_tag   (div_tag)
    );

    rbd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_tot    (div_tot),
        .in_cnt    (div_cnt),
        .in_tag    (div_tag),
        .out_valid (dst_valid),
        .out_quo   (quo),
        .out_tag   (tag_o)
    );

    assign dst_pixel = {quo[rbd_pkg::CH_R][rbd_pkg::RED_W-1:0],
                        quo[rbd_pkg::CH_G][rbd_pkg::GRN_W-1:0],
                        quo[rbd_pkg::CH_B][rbd_pkg::BLU_W-1:0]};
    assign dst_col   = COL_OUT_W'(tag_o.col);
    assign dst_row   = ROW_OUT_W'(tag_o.row);
    assign row_done  = tag_o.row_done;

`ifndef SYNTHESIS
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> !src_stall)
        else $error("input stalled with an empty output stage");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bcol_reg < rbd_pkg::DST_WIDTH) && (col_cnt_reg < rbd_pkg::SRC_WIDTH)
        && (brow_reg < rbd_pkg::DST_HEIGHT) && (row_cnt_reg < rbd_pkg::SRC_HEIGHT))
        else $error("frame position out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/rbd_column_acc.sv =====
`default_nettype none
// ============================================================================
// rbd_column_acc
// Line store of per-column partial box sums: read when an item ending a box
// column is taken; add, write back a stage on, with write-to-read forwarding.
// ============================================================================
module rbd_column_acc (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire rbd_pkg::acc_ctrl_t  in_ctrl,
    input  wire rbd_pkg::rgb_sum_t   in_run,
    output logic                     out_valid,
    output rbd_pkg::rgb_sum_t        out_tot,
    output logic [rbd_pkg::CNT_W-1:0] out_cnt,
    output rbd_pkg::box_tag_t        out_tag
);

    localparam int CNT_W = rbd_pkg::CNT_W;

    rbd_pkg::rgb_sum_t  mem [rbd_pkg::DST_WIDTH];

    logic               v1_reg;
    rbd_pkg::acc_ctrl_t ctrl1_reg;
    rbd_pkg::rgb_sum_t  run1_reg;
    rbd_pkg::rgb_sum_t  rd_data_reg;
    logic               fwd_hit_reg;
    rbd_pkg::rgb_sum_t  fwd_data_reg;

    logic                       rd_en;
    logic                       wr_en;
    logic [rbd_pkg::ADDR_W-1:0] wr_addr;
    rbd_pkg::rgb_sum_t          prev;
    rbd_pkg::rgb_sum_t          tot;
    rbd_pkg::rgb_sum_t          wr_data;

    assign rd_en   = in_valid && in_ctrl.col_last;
    assign wr_en   = adv && v1_reg && ctrl1_reg.col_last;
    assign wr_addr = ctrl1_reg.addr;

    always_comb
    begin
        if (ctrl1_reg.first_row)
            prev = '0;
        else if (fwd_hit_reg)
            prev = fwd_data_reg;
        else
            prev = rd_data_reg;
        for (int k = 0; k < 3; k++)
        begin
            tot[k] = prev[k] + run1_reg[k];
        end
        // a finished box leaves its column cleared for the next box row
        wr_data = ctrl1_reg.row_last ? '0 : tot;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[in_ctrl.addr];
            fwd_hit_reg  <= wr_en && (wr_addr == in_ctrl.addr);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            ctrl1_reg <= in_ctrl;
            run1_reg  <= in_run;
        end
    end

    assign out_valid = v1_reg && ctrl1_reg.col_last && ctrl1_reg.row_last;
    assign out_tot   = tot;
    assign out_cnt   = CNT_W'(ctrl1_reg.cw) * CNT_W'(ctrl1_reg.rh);
    assign out_tag   = ctrl1_reg.tag;

`ifndef SYNTHESIS
    a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr < rbd_pkg::DST_WIDTH))
        else $error("line store write beyond last box column");
`endif

endmodule
`default_nettype wire

// ===== rtl/rbd_divider.sv =====
`default_nettype none
// ============================================================================
// rbd_divider
// Pipelined restoring divider: three channel sums by the box pixel count,
// one quotient bit per stage, with the box tag carried alongside.
// ============================================================================
module rbd_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire rbd_pkg::rgb_sum_t         in_tot,
    input  wire logic [rbd_pkg::CNT_W-1:0] in_cnt,
    input  wire rbd_pkg::box_tag_t         in_tag,
    output logic                           out_valid,
    output rbd_pkg::rgb_quo_t              out_quo,
    output rbd_pkg::box_tag_t              out_tag
);

    localparam int QUO_W = rbd_pkg::QUO_W;
    localparam int SUM_W = rbd_pkg::SUM_W;
    localparam int CMP_W = rbd_pkg::SUM_W + rbd_pkg::QUO_W;

    logic [QUO_W:0]             v_reg;
    rbd_pkg::rgb_sum_t          rem_reg [QUO_W+1];
    rbd_pkg::rgb_quo_t          quo_reg [QUO_W+1];
    logic [rbd_pkg::CNT_W-1:0]  cnt_reg [QUO_W+1];
    rbd_pkg::box_tag_t          tag_reg [QUO_W+1];

    rbd_pkg::rgb_sum_t          rem_n [QUO_W];
    rbd_pkg::rgb_quo_t          quo_n [QUO_W];

    // stage j settles quotient bit QUO_W-1-j
    always_comb
    begin
        logic [CMP_W-1:0] dvs;
        logic [CMP_W-1:0] rem_ext;
        for (int j = 0; j < QUO_W; j++)
        begin
            dvs = CMP_W'(cnt_reg[j]) << (QUO_W - 1 - j);
            for (int k = 0; k < 3; k++)
            begin
                rem_ext     = CMP_W'(rem_reg[j][k]);
                rem_n[j][k] = rem_reg[j][k];
                quo_n[j][k] = quo_reg[j][k];
                if (rem_ext >= dvs)
                begin
                    rem_n[j][k]                = SUM_W'(rem_ext - dvs);
                    quo_n[j][k][QUO_W - 1 - j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[QUO_W-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= in_tot;
            quo_reg[0] <= '0;
            cnt_reg[0] <= in_cnt;
            tag_reg[0] <= in_tag;
            for (int j = 0; j < QUO_W; j++)
            begin
                rem_reg[j+1] <= rem_n[j];
                quo_reg[j+1] <= quo_n[j];
                cnt_reg[j+1] <= cnt_reg[j];
                tag_reg[j+1] <= tag_reg[j];
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_tag   = tag_reg[QUO_W];

`ifndef SYNTHESIS
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> (cnt_reg[0] != '0))
        else $error("box pixel count is zero");

    a_rem_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QUO_W] |-> ((rem_reg[QUO_W][rbd_pkg::CH_R] < cnt_reg[QUO_W])
                       && (rem_reg[QUO_W][rbd_pkg::CH_G] < cnt_reg[QUO_W])
                       && (rem_reg[QUO_W][rbd_pkg::CH_B] < cnt_reg[QUO_W])))
        else $error("division left a remainder not below the count");
`endif

endmodule
`default_nettype wire

// ===== tb/rgb565_box_downscaler_unit_tb.sv =====
`default_nettype none
// ============================================================================
// rgb565_box_downscaler_unit_tb
// Self-checking bench for the RGB565 box-averaging downscaler.
// ============================================================================
// A queue of source pixels feeds a clocked driver under valid/stall. Each
// accepted item updates a behavioral copy of the downscaler: raster position,
// box edges, row-segment sums and per-column line sums. Boxes completed by
// the item push an expected averaged pixel. A clocked monitor with random
// output stall pops and compares every emitted pixel field by field.
// Stimulus: short directed cases (channel extremes, truncation, frame start
// inside a box), then one run from a frame start over the first two source
// rows and into the third, so box row 1 is finished from line store sums.
// ============================================================================
module rgb565_box_downscaler_unit_tb;

    localparam int SRC_WIDTH  = rbd_pkg::SRC_WIDTH;
    localparam int SRC_HEIGHT = rbd_pkg::SRC_HEIGHT;
    localparam int DST_WIDTH  = rbd_pkg::DST_WIDTH;
    localparam int DST_HEIGHT = rbd_pkg::DST_HEIGHT;
    localparam int PIX_W      = rbd_pkg::PIX_W;
    localparam int COL_OUT_W  = rbd_pkg::COL_OUT_W;
    localparam int ROW_OUT_W  = rbd_pkg::ROW_OUT_W;
    localparam int RED_POS    = rbd_pkg::RED_POS;
    localparam int GRN_POS    = rbd_pkg::GRN_POS;
    localparam int BLU_POS    = rbd_pkg::BLU_POS;
    localparam int RED_W      = rbd_pkg::RED_W;
    localparam int GRN_W      = rbd_pkg::GRN_W;
    localparam int BLU_W      = rbd_pkg::BLU_W;
    localparam int CH_R       = rbd_pkg::CH_R;
    localparam int CH_G       = rbd_pkg::CH_G;
    localparam int CH_B       = rbd_pkg::CH_B;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT = 17;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             fs;
    } src_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pix;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 done;
    } box_pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    logic [PIX_W-1:0]     src_pixel = '0;
    logic                 frame_start = 1'b0;
    logic                 dst_valid;
    logic                 dst_stall = 1'b0;
    logic [PIX_W-1:0]     dst_pixel;
    logic [COL_OUT_W-1:0] dst_col;
    logic [ROW_OUT_W-1:0] dst_row;
    logic                 row_done;

    src_item_t  pending_src[$];
    box_pixel_t box_pixels_due[$];

    int src_taken = 0;
    int pixels_checked = 0;
    int n_mismatch = 0;
    int quiet = 0;

    // predictor state: source position, current box and its exclusive ends
    int unsigned src_x, src_y, box_x, box_y, box_x_end, box_y_end;
    int unsigned seg_sum [3];
    int unsigned col_acc [DST_WIDTH][3];

    // no idling in a long stretch of the long run
    wire calm = (src_taken >= 300) && (src_taken < 450);

    rgb565_box_downscaler_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_pixel   (src_pixel),
        .frame_start (frame_start),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .dst_pixel   (dst_pixel),
        .dst_col     (dst_col),
        .dst_row     (dst_row),
        .row_done    (row_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned box_bound(int unsigned i, int unsigned src,
                                              int unsigned dst);
        return (i * src) / dst;
    endfunction

    task automatic restart_position();
        src_x = 0;
        src_y = 0;
        box_x = 0;
        box_y = 0;
        box_x_end = box_bound(1, SRC_WIDTH, DST_WIDTH);
        box_y_end = box_bound(1, SRC_HEIGHT, DST_HEIGHT);
        for (int k = 0; k < 3; k++)
        begin
            seg_sum[k] = 0;
        end
    endtask

    task automatic predict_box_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned chan [3];
        int unsigned tot [3];
        bit [31:0]   avg [3];
        int unsigned cnt;
        bit          col_last, row_last, first_row;
        box_pixel_t  want;
        if (fs)
            restart_position();
        chan[CH_R] = pix[RED_POS +: RED_W];
        chan[CH_G] = pix[GRN_POS +: GRN_W];
        chan[CH_B] = pix[BLU_POS +: BLU_W];
        for (int k = 0; k < 3; k++)
        begin
            seg_sum[k] += chan[k];
        end
        col_last = (src_x + 1 >= box_x_end);
        row_last = (src_y + 1 >= box_y_end);
        first_row = (src_y <= box_bound(box_y, SRC_HEIGHT, DST_HEIGHT));
        if (col_last)
        begin
            // top source row of a box row ignores what the line store holds
            for (int k = 0; k < 3; k++)
            begin
                tot[k] = (first_row ? 0 : col_acc[box_x][k]) + seg_sum[k];
                col_acc[box_x][k] = row_last ? 0 : tot[k];
                seg_sum[k] = 0;
            end
            if (row_last)
            begin
                cnt = (box_x_end - box_bound(box_x, SRC_WIDTH, DST_WIDTH))
                    * (box_y_end - box_bound(box_y, SRC_HEIGHT, DST_HEIGHT));
                for (int k = 0; k < 3; k++)
                begin
                    avg[k] = (cnt != 0) ? tot[k] / cnt : 0;
                end
                want.pix  = {avg[CH_R][RED_W-1:0], avg[CH_G][GRN_W-1:0],
                             avg[CH_B][BLU_W-1:0]};
                want.col  = box_x[COL_OUT_W-1:0];
                want.row  = box_y[ROW_OUT_W-1:0];
                want.done = (box_x + 1 >= DST_WIDTH);
                box_pixels_due.push_back(want);
            end
        end
        src_x++;
        if (col_last)
        begin
            box_x++;
            box_x_end = box_bound(box_x + 1, SRC_WIDTH, DST_WIDTH);
        end
        if (src_x >= SRC_WIDTH)
        begin
            src_x = 0;
            box_x = 0;
            box_x_end = box_bound(1, SRC_WIDTH, DST_WIDTH);
            for (int k = 0; k < 3; k++)
            begin
                seg_sum[k] = 0;
            end
            src_y++;
            if (row_last)
            begin
                box_y++;
                box_y_end = box_bound(box_y + 1, SRC_HEIGHT, DST_HEIGHT);
            end
            if (src_y >= SRC_HEIGHT)
            begin
                src_y = 0;
                box_y = 0;
                box_y_end = box_bound(1, SRC_HEIGHT, DST_HEIGHT);
            end
        end
    endtask

    task automatic queue_px(input logic [PIX_W-1:0] pix, input logic fs);
        src_item_t it;
        it.pix = pix;
        it.fs = fs;
        pending_src.push_back(it);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] corner [5];
        corner = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
        if ($urandom_range(99) < 10)
            return corner[$urandom_range(4)];
        return PIX_W'($urandom);
    endfunction

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        src_item_t nxt;
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_pixel <= '0;
            frame_start <= 1'b0;
        end
        else
        begin
            if (src_valid && !src_stall)
            begin
                predict_box_pixel(src_pixel, frame_start);
                src_taken <= src_taken + 1;
            end
            if (!src_valid || !src_stall)
            begin
                if (pending_src.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_src.pop_front();
                    src_valid <= 1'b1;
                    src_pixel <= nxt.pix;
                    frame_start <= nxt.fs;
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        box_pixel_t want;
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
        end
        else
        begin
            if (dst_valid && !dst_stall)
            begin
                pixels_checked <= pixels_checked + 1;
                if (box_pixels_due.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected item: pixel %h col %0d row %0d done %b",
                                 dst_pixel, dst_col, dst_row, row_done);
                end
                else
                begin
                    want = box_pixels_due.pop_front();
                    if (dst_pixel !== want.pix || dst_col !== want.col ||
                        dst_row !== want.row || row_done !== want.done)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: got %h c%0d r%0d d%b, want %h c%0d r%0d d%b",
                                     dst_pixel, dst_col, dst_row, row_done,
                                     want.pix, want.col, want.row, want.done);
                    end
                end
            end
            dst_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog: cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        restart_position();
        for (int c = 0; c < DST_WIDTH; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                col_acc[c][k] = 0;
            end
        end

        // directed: extremes, per-channel averages, truncation to zero
        queue_px(16'hFFFF, 1'b1);
        queue_px(16'hFFFF, 1'b0);
        queue_px(16'h0000, 1'b0);
        queue_px(16'h0000, 1'b0);
        queue_px(16'hF800, 1'b0);
        queue_px(16'h07E0, 1'b0);
        queue_px(16'h001F, 1'b0);
        queue_px(16'h0000, 1'b0);
        queue_px(16'h0001, 1'b0);
        queue_px(16'h0820, 1'b0);
        // frame start on the second pixel of a box drops the partial sum
        queue_px(16'hFFFF, 1'b0);
        queue_px(16'hFFFF, 1'b1);
        queue_px(16'h0000, 1'b0);
        queue_px(16'hAAAA, 1'b0);
        queue_px(16'h5555, 1'b1);
        queue_px(16'h5555, 1'b0);

        // two full source rows and the head of the third: the third row
        // closes boxes of box row 1 from sums held in the line store
        queue_px(pick_pixel(), 1'b1);
        for (int i = 1; i < 2 * SRC_WIDTH + 16; i++)
        begin
            queue_px(pick_pixel(), 1'b0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_src.size() != 0 || src_valid)
            @(posedge clk);
        while (box_pixels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("fed %0d source pixels: directed cases, then rows 0-2 from a frame start",
                 src_taken);
        $display("compared %0d averaged pixels, %0d mismatches", pixels_checked, n_mismatch);
        if (n_mismatch == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
